// ===== rtl/sma_pkg.sv =====
// Package for the stack machine ALU: opcode and status codes.
// No dependencies.
package sma_pkg;

  typedef enum logic [4:0] {
    OP_PUSH = 5'd0,
    OP_ADD  = 5'd1,
    OP_SUB  = 5'd2,
    OP_MUL  = 5'd3,
    OP_DIV  = 5'd4,
    OP_MOD  = 5'd5,
    OP_LT   = 5'd6,
    OP_LE   = 5'd7,
    OP_GT   = 5'd8,
    OP_GE   = 5'd9,
    OP_EQ   = 5'd10,
    OP_DUP  = 5'd11,
    OP_DUP2 = 5'd12,
    OP_DROP = 5'd13,
    OP_SWAP = 5'd14,
    OP_ROT  = 5'd15,
    OP_EMIT = 5'd16
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_MODZ  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_OVER  = 3'd4
  } status_t;

endpackage

// ===== rtl/stack_machine_alu_top.sv =====
// Stack machine ALU top level: sequencer, stack memory and shared divider.
// Depends on sma_pkg.
//
// Forth-style data stack executor. One transaction in gives one transaction
// out. The stack lives in a RAM with one registered read port and one write
// port, so operands are read one per cycle. Each transaction reads the top
// three words, executes, runs the bit-serial divider for divide and modulo
// by a nonzero divisor, writes back one to three words (none for drop, emit
// or an error), then reads the new top and presents the result. in_stall is
// high from acceptance until the result is taken. The store is not cleared;
// stack_count resets to zero.
module stack_machine_alu_top
  import sma_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         in_opcode,
  input  logic signed [31:0] in_literal,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_top_value,
  output logic [6:0]         out_stack_count,
  output logic               out_emit_valid,
  output logic [7:0]         out_emit_char
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RDA   = 11'b00000000010,
    S_RDB   = 11'b00000000100,
    S_RDC   = 11'b00000001000,
    S_EXEC  = 11'b00000010000,
    S_DIV   = 11'b00000100000,
    S_WR0   = 11'b00001000000,
    S_WR1   = 11'b00010000000,
    S_WR2   = 11'b00100000000,
    S_RDTOP = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [4:0]       op_r;
  logic [31:0]      lit_r, a_r, b_r, c_r, res_r;
  logic [CW-1:0]    cnt_r;
  logic [2:0]       status_r;
  logic             emv_r;
  logic [7:0]       emc_r;
  logic [31:0]      mem [STACK_DEPTH];
  logic [31:0]      rdata_r;
  logic [AW-1:0]    raddr;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [31:0]      wdata;
  // divider
  logic [31:0]      dq_r, dr_r, dd_r;
  logic [5:0]       di_r;
  logic [32:0]      dtrial;

  logic [2:0] need;
  logic [1:0] grow;
  always_comb begin
    need = 3'd0;
    grow = 2'd0;
    unique case (op_r)
      OP_PUSH: grow = 2'd1;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_LT, OP_LE, OP_GT, OP_GE,
      OP_EQ, OP_SWAP: need = 3'd2;
      OP_DUP: begin need = 3'd1; grow = 2'd1; end
      OP_DUP2: begin need = 3'd2; grow = 2'd2; end
      OP_ROT: need = 3'd3;
      default: need = 3'd0;
    endcase
  end

  logic under, over;
  assign under = {{CW{1'b0}}, need} > {3'd0, cnt_r};
  assign over  = (CW+1)'(cnt_r) + (CW+1)'(grow) > (CW+1)'(STACK_DEPTH);

  function automatic logic slt(input logic [31:0] x, input logic [31:0] y);
    return $signed(x) < $signed(y);
  endfunction

  logic [31:0] abs_a, abs_b;
  assign abs_a = a_r[31] ? -a_r : a_r;
  assign abs_b = b_r[31] ? -b_r : b_r;
  assign dtrial = {dr_r, dd_r[31]} - {1'b0, dq_r};

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  logic [AW-1:0] top_idx;
  assign top_idx = AW'(cnt_r - CW'(1));

  always_comb begin
    raddr = top_idx;
    we = 1'b0;
    waddr = top_idx;
    wdata = res_r;
    unique case (state_r)
      S_RDA: raddr = AW'(cnt_r - CW'(2));
      S_RDB: raddr = AW'(cnt_r - CW'(3));
      S_WR0: begin
        we = 1'b1;
        unique case (op_r)
          OP_DUP2: begin waddr = AW'(cnt_r - CW'(2)); wdata = b_r; end
          OP_SWAP: begin waddr = AW'(cnt_r - CW'(1)); wdata = b_r; end
          OP_ROT:  begin waddr = AW'(cnt_r - CW'(1)); wdata = c_r; end
          default: begin waddr = AW'(cnt_r - CW'(1)); wdata = res_r; end
        endcase
      end
      S_WR1: begin
        we = 1'b1;
        unique case (op_r)
          OP_DUP2: begin waddr = AW'(cnt_r - CW'(1)); wdata = a_r; end
          OP_SWAP: begin waddr = AW'(cnt_r - CW'(2)); wdata = a_r; end
          default: begin waddr = AW'(cnt_r - CW'(2)); wdata = a_r; end
        endcase
      end
      S_WR2: begin
        we = 1'b1;
        waddr = AW'(cnt_r - CW'(3));
        wdata = b_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_RDA;
      S_RDA:   state_nxt = S_RDB;
      S_RDB:   state_nxt = S_RDC;
      S_RDC:   state_nxt = S_EXEC;
      S_EXEC:  begin
        if (under || (over && grow != 2'd0)) state_nxt = S_RDTOP;
        else if ((op_r == OP_DIV || op_r == OP_MOD) && b_r != 32'd0)
          state_nxt = S_DIV;
        else if (op_r == OP_PUSH || op_r == OP_DUP || op_r == OP_DUP2 ||
                 op_r == OP_SWAP || op_r == OP_ROT ||
                 (op_r >= OP_ADD && op_r <= OP_EQ && b_r != 32'd0) ||
                 (op_r >= OP_ADD && op_r <= OP_EQ && op_r != OP_DIV &&
                  op_r != OP_MOD))
          state_nxt = S_WR0;
        else state_nxt = S_RDTOP;
      end
      S_DIV:   if (di_r == 6'd32) state_nxt = S_WR0;
      S_WR0:   state_nxt = (op_r == OP_DUP2 || op_r == OP_SWAP || op_r == OP_ROT)
                           ? S_WR1 : S_RDTOP;
      S_WR1:   state_nxt = (op_r == OP_ROT) ? S_WR2 : S_RDTOP;
      S_WR2:   state_nxt = S_RDTOP;
      S_RDTOP: state_nxt = S_OUT;
      S_OUT:   if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          op_r <= in_opcode;
          lit_r <= in_literal;
          status_r <= ST_OK;
          emv_r <= 1'b0;
          emc_r <= 8'd0;
        end
        S_RDA: a_r <= rdata_r;
        S_RDB: b_r <= rdata_r;
        S_RDC: c_r <= rdata_r;
        S_EXEC: begin
          if (under) status_r <= ST_UNDER;
          else if (over && grow != 2'd0) status_r <= ST_OVER;
          else begin
            priority case (1'b1)
              (op_r == OP_PUSH): begin res_r <= lit_r; cnt_r <= cnt_r + CW'(1); end
              (op_r == OP_DUP):  begin res_r <= a_r; cnt_r <= cnt_r + CW'(1); end
              (op_r == OP_DUP2): cnt_r <= cnt_r + CW'(2);
              (op_r == OP_DROP): if (cnt_r != '0) cnt_r <= cnt_r - CW'(1);
              (op_r == OP_EMIT): if (cnt_r != '0) begin
                cnt_r <= cnt_r - CW'(1);
                emv_r <= 1'b1;
                emc_r <= a_r[7:0];
              end
              (op_r >= OP_ADD && op_r <= OP_EQ): begin
                if ((op_r == OP_DIV || op_r == OP_MOD) && b_r == 32'd0)
                  cnt_r <= cnt_r - CW'(2);
                else cnt_r <= cnt_r - CW'(1);
                unique case (op_r)
                  OP_ADD: res_r <= a_r + b_r;
                  OP_SUB: res_r <= a_r - b_r;
                  OP_MUL: res_r <= a_r * b_r;
                  OP_LT:  res_r <= {31'd0, slt(a_r, b_r)};
                  OP_LE:  res_r <= {31'd0, !slt(b_r, a_r)};
                  OP_GT:  res_r <= {31'd0, slt(b_r, a_r)};
                  OP_GE:  res_r <= {31'd0, !slt(a_r, b_r)};
                  OP_EQ:  res_r <= {31'd0, a_r == b_r};
                  default: begin
                    if (b_r == 32'd0)
                      status_r <= (op_r == OP_MOD) ? ST_MODZ : ST_DIVZ;
                    dq_r <= abs_b;
                    dd_r <= abs_a;
                    dr_r <= 32'd0;
                    di_r <= 6'd0;
                  end
                endcase
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (di_r == 6'd32) begin
            if (op_r == OP_DIV) res_r <= (a_r[31] ^ b_r[31]) ? -dd_r : dd_r;
            else res_r <= a_r[31] ? -dr_r : dr_r;
          end else begin
            di_r <= di_r + 6'd1;
            if (!dtrial[32]) begin
              dr_r <= dtrial[31:0];
              dd_r <= {dd_r[30:0], 1'b1};
            end else begin
              dr_r <= {dr_r[30:0], dd_r[31]};
              dd_r <= {dd_r[30:0], 1'b0};
            end
          end
        end
        S_RDTOP: ;
        default: ;
      endcase
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_status      = status_r;
  assign out_top_value   = (cnt_r == '0) ? 32'sd0 : $signed(rdata_r);
  assign out_stack_count = 7'(cnt_r);
  assign out_emit_valid  = emv_r;
  assign out_emit_char   = emc_r;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CW+1)'(cnt_r) <= (CW+1)'(STACK_DEPTH)) else $error("stack count out of range");
  a_emit_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_emit_valid |-> out_status == ST_OK) else $error("emit with error");
  a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> di_r <= 6'd32) else $error("divider overrun");
`endif

endmodule

// ===== test/stack_machine_alu_top_test.sv =====
// Testbench for stack_machine_alu_top: drives opcode transactions, predicts
// each result with a behavioral data-stack model and checks every output field.
// Depends on sma_pkg and stack_machine_alu_top.
`timescale 1ns / 1ps

module stack_machine_alu_top_test;
  import sma_pkg::*;

  localparam int DEPTH = 64;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [31:0] literal;
  } op_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] top_value;
    logic [6:0]  stack_count;
    logic        emit_valid;
    logic [7:0]  emit_char;
  } stack_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [4:0] in_opcode = '0;
  logic signed [31:0] in_literal = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic signed [31:0] out_top_value;
  logic [6:0] out_stack_count;
  logic out_emit_valid;
  logic [7:0] out_emit_char;

  op_item_t pending_ops[$];
  stack_result_t expected_results[$];
  logic [31:0] model_stack[DEPTH];
  int model_depth = 0;
  int errors = 0;
  bit quiet_mode = 1'b0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_cycles = 0;

  stack_machine_alu_top #(.STACK_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_literal(in_literal),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_top_value(out_top_value),
    .out_stack_count(out_stack_count), .out_emit_valid(out_emit_valid),
    .out_emit_char(out_emit_char)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] abs_word(logic [31:0] v);
    return v[31] ? 32'd0 - v : v;
  endfunction

  function automatic stack_result_t execute_op(op_item_t it);
    stack_result_t r;
    logic [31:0] a, b, c, v;
    bit keep;
    int n;
    r = '0;
    n = model_depth;
    a = (n >= 1) ? model_stack[n-1] : '0;
    b = (n >= 2) ? model_stack[n-2] : '0;
    c = (n >= 3) ? model_stack[n-3] : '0;
    keep = 1'b1;
    v = '0;
    if (it.opcode >= OP_ADD && it.opcode <= OP_EQ) begin
      if (n < 2) begin
        r.status = ST_UNDER;
      end else begin
        model_depth = n - 2;
        case (opcode_t'(it.opcode))
          OP_ADD: v = a + b;
          OP_SUB: v = a - b;
          OP_MUL: v = a * b;
          OP_DIV: begin
            if (b == 0) begin
              r.status = ST_DIVZ;
              keep = 1'b0;
            end else begin
              v = abs_word(a) / abs_word(b);
              if (a[31] ^ b[31]) v = 32'd0 - v;
            end
          end
          OP_MOD: begin
            if (b == 0) begin
              r.status = ST_MODZ;
              keep = 1'b0;
            end else begin
              v = abs_word(a) % abs_word(b);
              if (a[31]) v = 32'd0 - v;
            end
          end
          OP_LT: v = ($signed(a) < $signed(b)) ? 1 : 0;
          OP_LE: v = ($signed(a) <= $signed(b)) ? 1 : 0;
          OP_GT: v = ($signed(a) > $signed(b)) ? 1 : 0;
          OP_GE: v = ($signed(a) >= $signed(b)) ? 1 : 0;
          default: v = (a == b) ? 1 : 0;
        endcase
        if (keep) begin
          model_stack[model_depth] = v;
          model_depth++;
        end
      end
    end else begin
      case (it.opcode)
        OP_PUSH: begin
          if (n >= DEPTH) r.status = ST_OVER;
          else begin
            model_stack[n] = it.literal;
            model_depth = n + 1;
          end
        end
        OP_DUP: begin
          if (n < 1) r.status = ST_UNDER;
          else if (n + 1 > DEPTH) r.status = ST_OVER;
          else begin
            model_stack[n] = a;
            model_depth = n + 1;
          end
        end
        OP_DUP2: begin
          if (n < 2) r.status = ST_UNDER;
          else if (n + 2 > DEPTH) r.status = ST_OVER;
          else begin
            model_stack[n] = b;
            model_stack[n+1] = a;
            model_depth = n + 2;
          end
        end
        OP_DROP: if (n >= 1) model_depth = n - 1;
        OP_SWAP: begin
          if (n < 2) r.status = ST_UNDER;
          else begin
            model_stack[n-1] = b;
            model_stack[n-2] = a;
          end
        end
        OP_ROT: begin
          if (n < 3) r.status = ST_UNDER;
          else begin
            model_stack[n-3] = b;
            model_stack[n-2] = a;
            model_stack[n-1] = c;
          end
        end
        OP_EMIT: begin
          if (n >= 1) begin
            model_depth = n - 1;
            r.emit_valid = 1'b1;
            r.emit_char = a[7:0];
          end
        end
        default: ;
      endcase
    end
    r.top_value = (model_depth >= 1) ? model_stack[model_depth-1] : '0;
    r.stack_count = model_depth[6:0];
    return r;
  endfunction

  function automatic logic [31:0] random_literal();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return '0;
      4, 5: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(logic [4:0] op, logic [31:0] lit);
    op_item_t it;
    it.opcode = op;
    it.literal = lit;
    pending_ops.push_back(it);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(execute_op(pending_ops.pop_front()));
      end
      if (!in_valid || !in_stall) begin
        if (pending_ops.size() > 0 && (quiet_mode || $urandom_range(0, 99) >= 29)) begin
          in_valid <= 1'b1;
          in_opcode <= pending_ops[0].opcode;
          in_literal <= pending_ops[0].literal;
        end else begin
          in_valid <= 1'b0;
          in_opcode <= 5'($urandom);
          in_literal <= $urandom;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_req && !hold_seen) begin
        hold_seen <= 1'b1;
        hold_cycles <= 200;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    stack_result_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected transaction, actual %h/%h/%0d/%b/%h", $time,
                   out_status, out_top_value, out_stack_count, out_emit_valid,
                   out_emit_char);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, out_status);
            errors++;
          end
          if (out_top_value !== exp_r.top_value) begin
            $display("%0t: top_value expected %h actual %h", $time, exp_r.top_value,
                     out_top_value);
            errors++;
          end
          if (out_stack_count !== exp_r.stack_count) begin
            $display("%0t: stack_count expected %0d actual %0d", $time,
                     exp_r.stack_count, out_stack_count);
            errors++;
          end
          if (out_emit_valid !== exp_r.emit_valid) begin
            $display("%0t: emit_valid expected %b actual %b", $time, exp_r.emit_valid,
                     out_emit_valid);
            errors++;
          end
          if (out_emit_char !== exp_r.emit_char) begin
            $display("%0t: emit_char expected %h actual %h", $time, exp_r.emit_char,
                     out_emit_char);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet_mode && ($urandom_range(0, 99) < 29);
      end
    end
  end

  initial begin
    int depth_est;
    int op;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: underflow on empty, empty drop/emit, stack ops, divide corners
    queue_op(OP_DROP, 0);
    queue_op(OP_EMIT, 0);
    queue_op(OP_ADD, 0);
    queue_op(OP_DUP, 0);
    queue_op(OP_PUSH, 32'h8000_0000);
    queue_op(OP_SWAP, 0);
    queue_op(OP_PUSH, 32'hffff_ffff);
    queue_op(OP_SWAP, 0);
    queue_op(OP_DIV, 0);
    queue_op(OP_PUSH, 32'hffff_ffff);
    queue_op(OP_PUSH, 32'h8000_0000);
    queue_op(OP_MOD, 0);
    queue_op(OP_PUSH, 0);
    queue_op(OP_PUSH, 32'h7fff_ffff);
    queue_op(OP_DIV, 0);
    queue_op(OP_PUSH, 0);
    queue_op(OP_PUSH, 32'd7);
    queue_op(OP_MOD, 0);
    queue_op(OP_PUSH, 3);
    queue_op(OP_PUSH, -7);
    queue_op(OP_DUP2, 0);
    queue_op(OP_ROT, 0);
    queue_op(OP_EMIT, 0);
    queue_op(5'd31, 0);
    queue_op(5'd17, 0);

    // fill to full then overflow
    for (int i = 0; i < 66; i++) queue_op(OP_PUSH, random_literal());
    queue_op(OP_DUP, 0);
    queue_op(OP_DUP2, 0);
    for (int i = 0; i < 70; i++) queue_op(OP_DROP, 0);

    // receiver holds off while sender keeps offering
    wait (pending_ops.size() == 0);
    hold_req = 1'b1;
    for (int i = 0; i < 10; i++) queue_op(OP_PUSH, $urandom);
    wait (pending_ops.size() == 0);

    // random: mostly keep depth mid-range, with sweeps toward extremes
    depth_est = 0;
    for (int i = 0; i < 1720; i++) begin
      if (i == 900) begin
        wait (pending_ops.size() == 0 && expected_results.size() == 0);
        quiet_mode = 1'b1;
        for (int j = 0; j < 60; j++) queue_op(5'($urandom_range(0, 16)), random_literal());
        wait (pending_ops.size() == 0);
        quiet_mode = 1'b0;
      end
      if (depth_est < 3 || (i % 400 > 300 && depth_est < 66)) op = OP_PUSH;
      else if (depth_est > 60 && $urandom_range(0, 1)) op = OP_DROP;
      else if ($urandom_range(0, 19) == 0) op = $urandom_range(17, 31);
      else op = $urandom_range(0, 16);
      queue_op(5'(op), random_literal());
      case (op)
        OP_PUSH, OP_DUP: depth_est++;
        OP_DUP2: depth_est += 2;
        OP_DROP, OP_EMIT, OP_ADD, OP_SUB, OP_MUL, OP_LT, OP_LE, OP_GT,
        OP_GE, OP_EQ: depth_est--;
        OP_DIV, OP_MOD: depth_est -= 2;
        default: ;
      endcase
      if (depth_est < 0) depth_est = 0;
      if (depth_est > 64) depth_est = 64;
    end
    wait (pending_ops.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
